// File: src/wsi_pkg.sv
// ----------------------------------------------------------------------------
// wsi_pkg: shared types and constants of the waypoint smoothstep interpolator
// Holds the payload structs, the segment job passed from front to back, and
// fixed-point constants.
// ----------------------------------------------------------------------------
package wsi_pkg;

    localparam int unsigned POS_W  = 32;
    localparam int unsigned QUAT_W = 16;
    localparam int unsigned T_W    = 17;          // t in 0..65536
    localparam logic [31:0] RES_RESET = 32'd13107;
    localparam logic signed [15:0] QUAT_ONE = 16'sd16384;

    typedef struct packed {
        logic                     path_start;
        logic signed [31:0]       way_x;
        logic signed [31:0]       way_y;
        logic signed [31:0]       way_z;
        logic signed [15:0]       way_qx;
        logic signed [15:0]       way_qy;
        logic signed [15:0]       way_qz;
        logic signed [15:0]       way_qw;
    } t_way;

    typedef struct packed {
        logic signed [31:0]       out_x;
        logic signed [31:0]       out_y;
        logic signed [31:0]       out_z;
        logic signed [15:0]       out_qx;
        logic signed [15:0]       out_qy;
        logic signed [15:0]       out_qz;
        logic signed [15:0]       out_qw;
        logic                     segment_last;
    } t_pose;

    // Segment job: both endpoints and the step count
    typedef struct packed {
        logic signed [31:0]       ax;
        logic signed [31:0]       ay;
        logic signed [31:0]       az;
        logic signed [15:0]       aqx;
        logic signed [15:0]       aqy;
        logic signed [15:0]       aqz;
        logic signed [15:0]       aqw;
        logic signed [31:0]       bx;
        logic signed [31:0]       by;
        logic signed [31:0]       bz;
        logic signed [15:0]       bqx;
        logic signed [15:0]       bqy;
        logic signed [15:0]       bqz;
        logic signed [15:0]       bqw;
        logic [5:0]               count;
    } t_job;

endpackage

// File: src/wsi_if.sv
// ----------------------------------------------------------------------------
// wsi_if: valid/ready channel
// Carries one payload per beat between a source and a sink.
// ----------------------------------------------------------------------------
interface wsi_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: src/wsi_front.sv
// ----------------------------------------------------------------------------
// wsi_front: waypoint intake and step count
// Stores the previous waypoint, and for each segment finds the step count
// by trying n = 3..MAX one per cycle, then pushes a job.
// ----------------------------------------------------------------------------
module wsi_front #(
    parameter int unsigned MAX_STEPS = 63
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [31:0]    i_res,
    input  logic           i_way_valid,
    output logic           o_way_ready,
    input  wsi_pkg::t_way  i_way,
    output logic           o_job_valid,
    input  logic           i_job_ready,
    output wsi_pkg::t_job  o_job
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CNT  = 3'b010,
        S_PUSH = 3'b100
    } t_fstate;

    t_fstate          r_state, n_state;
    logic             r_have;
    wsi_pkg::t_job    r_job;
    logic [5:0]       r_n;
    logic [64:0]      r_d2;
    logic [75:0]      r_a2;      // (n*res)^2 for the candidate n
    logic [75:0]      r_inc;     // (2n+1)*res^2, step to the next square
    logic [63:0]      w_res2;
    logic [32:0]      w_dx, w_dy;
    logic [32:0]      w_mx, w_my;
    logic             w_store;

    assign o_way_ready = (r_state == S_IDLE);
    assign o_job_valid = (r_state == S_PUSH);
    assign o_job       = r_job;

    assign w_dx = {i_way.way_x[31], i_way.way_x} - {r_job.bx[31], r_job.bx};
    assign w_dy = {i_way.way_y[31], i_way.way_y} - {r_job.by[31], r_job.by};
    assign w_mx = w_dx[32] ? (33'd0 - w_dx) : w_dx;
    assign w_my = w_dy[32] ? (33'd0 - w_dy) : w_dy;
    assign w_res2 = 64'(i_res) * 64'(i_res);
    assign w_store = i_way.path_start || !r_have;

    // Advance the intake/count sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_way_valid && !w_store) n_state = S_CNT;
            S_CNT: begin
                if ((r_a2 > 76'(r_d2)) || (r_n >= 6'(MAX_STEPS))) n_state = S_PUSH;
            end
            S_PUSH: if (i_job_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_have  <= 1'b0;
            r_job.bx <= '0; r_job.by <= '0; r_job.bz <= '0;
            r_job.bqx <= '0; r_job.bqy <= '0; r_job.bqz <= '0; r_job.bqw <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE && i_way_valid) begin
                // Shift the stored waypoint to the start and take the new one
                r_have    <= 1'b1;
                r_job.ax  <= r_job.bx;  r_job.ay  <= r_job.by;  r_job.az  <= r_job.bz;
                r_job.aqx <= r_job.bqx; r_job.aqy <= r_job.bqy;
                r_job.aqz <= r_job.bqz; r_job.aqw <= r_job.bqw;
                r_job.bx  <= i_way.way_x;  r_job.by  <= i_way.way_y;
                r_job.bz  <= i_way.way_z;
                r_job.bqx <= i_way.way_qx; r_job.bqy <= i_way.way_qy;
                r_job.bqz <= i_way.way_qz; r_job.bqw <= i_way.way_qw;
                r_job.count <= 6'd2;
                r_n   <= 6'd3;
                r_a2  <= (76'(w_res2) << 3) + 76'(w_res2);
                r_inc <= (76'(w_res2) << 3) - 76'(w_res2);
                r_d2  <= 65'(w_mx * w_mx) + 65'(w_my * w_my);
            end else if (r_state == S_CNT) begin
                // Test one candidate count a cycle
                if (r_a2 <= 76'(r_d2) && r_n <= 6'(MAX_STEPS)) begin
                    r_job.count <= r_n;
                end
                r_n   <= r_n + 6'd1;
                r_a2  <= r_a2 + r_inc;
                r_inc <= r_inc + (76'(w_res2) << 1);
            end
        end
    end

    // Count never leaves its range while a job waits
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_valid |-> (r_job.count >= 6'd2 && r_job.count <= 6'(MAX_STEPS)))
        else $error("step count out of range");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_job_valid && !i_job_ready) |=> $stable(r_job))
        else $error("job changed while waiting");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_valid |-> r_have)
        else $error("job without previous waypoint");

endmodule

// File: src/wsi_queue.sv
// ----------------------------------------------------------------------------
// wsi_queue: two-entry job queue
// Decouples the intake from the pose generator.
// ----------------------------------------------------------------------------
module wsi_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  wsi_pkg::t_job i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output wsi_pkg::t_job o_data
);
    wsi_pkg::t_job r_mem [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    logic          w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    // Store on push, advance pointers
    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= 2'd2)
        else $error("queue overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (r_cnt == $past(r_cnt) + 2'd1))
        else $error("queue count slip");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) |-> (r_wp == r_rp))
        else $error("queue pointers differ when empty");

endmodule

// File: src/wsi_back.sv
// ----------------------------------------------------------------------------
// wsi_back: pose generator
// For each job emits count+1 poses; per pose a sequencer computes t by a
// serial divide, s by two multiplies, the blends, an isqrt of the quaternion
// norm and four serial divides, then holds the pose in an output register.
// ----------------------------------------------------------------------------
module wsi_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_valid,
    output logic          o_job_ready,
    input  wsi_pkg::t_job i_job,
    output logic          o_pose_valid,
    input  logic          i_pose_ready,
    output wsi_pkg::t_pose o_pose
);

    typedef enum logic [9:0] {
        B_IDLE = 10'b0000000001,
        B_TDIV = 10'b0000000010,
        B_S1   = 10'b0000000100,
        B_S2   = 10'b0000001000,
        B_POS  = 10'b0000010000,
        B_QB   = 10'b0000100000,
        B_SQ   = 10'b0001000000,
        B_SQRT = 10'b0010000000,
        B_QDIV = 10'b0100000000,
        B_OUT  = 10'b1000000000
    } t_bstate;

    t_bstate          r_state;
    wsi_pkg::t_job    r_job;
    logic [5:0]       r_j;
    // serial divider (also used for t): quotient, remainder, divisor
    logic [48:0]      r_num;
    logic [48:0]      r_quo;
    logic [48:0]      r_rem;
    logic [47:0]      r_div;
    logic [5:0]       r_bit;
    logic [16:0]      r_t;
    logic [33:0]      r_tt;
    logic [16:0]      r_s;
    logic signed [47:0] r_b [4];
    logic [65:0]      r_n2;
    logic [1:0]       r_qi;
    logic [65:0]      r_sq_res;
    logic [65:0]      r_sq_bit;
    logic signed [15:0] r_q [4];
    logic signed [31:0] r_px, r_py, r_pz;
    wsi_pkg::t_pose   r_pose;
    logic             r_pv;

    logic [49:0]      w_trial;
    logic [46:0]      w_mag;
    logic signed [15:0] w_qa, w_qb;
    logic signed [17:0] w_qd;
    logic [66:0]      w_sq_t;
    logic [32:0]      w_h;
    logic             w_load;

    assign o_job_ready  = (r_state == B_IDLE);
    assign o_pose_valid = r_pv;
    assign o_pose       = r_pose;

    assign w_trial = {r_rem, r_num[48]} - {2'b0, r_div};
    assign w_mag   = r_b[r_qi][47] ? 47'(-r_b[r_qi]) : 47'(r_b[r_qi]);
    assign w_sq_t  = {1'b0, r_sq_res} + {1'b0, r_sq_bit};
    assign w_h     = r_sq_res[32:0];
    assign w_load  = (r_state == B_OUT) && (!r_pv || i_pose_ready);

    always_comb begin
        case (r_qi)
            2'd0: begin w_qa = r_job.aqx; w_qb = r_job.bqx; end
            2'd1: begin w_qa = r_job.aqy; w_qb = r_job.bqy; end
            2'd2: begin w_qa = r_job.aqz; w_qb = r_job.bqz; end
            default: begin w_qa = r_job.aqw; w_qb = r_job.bqw; end
        endcase
        w_qd = 18'(w_qb) - 18'(w_qa);
    end

    // Blend a + sign(d)*round(|d|*w/65536)
    function automatic logic signed [31:0] f_blend(input logic signed [31:0] a,
                                                  input logic signed [31:0] b,
                                                  input logic [16:0] w);
        logic signed [32:0] d;
        logic [32:0]        m;
        logic [49:0]        p;
        logic [33:0]        r;
        d = 33'(b) - 33'(a);
        m = d[32] ? 33'(-d) : d;
        p = 50'(m) * 50'(w) + 50'd32768;
        r = p[49:16];
        f_blend = d[32] ? 32'(34'(a) - r) : 32'(34'(a) + r);
    endfunction

    // Sequence one pose after another
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_pv    <= 1'b0;
        end else begin
            if (r_pv && i_pose_ready && !w_load) r_pv <= 1'b0;
            case (r_state)
                B_IDLE: if (i_job_valid) begin
                    r_job   <= i_job;
                    r_j     <= 6'd0;
                    r_state <= B_TDIV;
                    r_num   <= 49'(i_job.count >> 1) << 26;
                    r_rem   <= '0;
                    r_quo   <= '0;
                    r_div   <= 48'(i_job.count);
                    r_bit   <= 6'd23;
                end
                B_TDIV: begin
                    // Restoring divide: one quotient bit a cycle
                    if (!w_trial[49]) begin
                        r_rem <= w_trial[48:0];
                        r_quo <= {r_quo[47:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[47:0], r_num[48]};
                        r_quo <= {r_quo[47:0], 1'b0};
                    end
                    r_num <= r_num << 1;
                    r_bit <= r_bit - 6'd1;
                    if (r_bit == 6'd1) r_state <= B_S1;
                end
                B_S1: begin
                    r_t  <= r_quo[16:0];
                    r_tt <= 34'(r_quo[16:0]) * 34'(r_quo[16:0]);
                    r_state <= B_S2;
                end
                B_S2: begin
                    r_s <= 17'((51'(r_tt) * 51'(18'd196608 - 18'({r_t, 1'b0}))
                                + 51'h80000000) >> 32);
                    r_qi <= 2'd0;
                    r_n2 <= '0;
                    r_state <= B_POS;
                end
                B_POS: begin
                    r_px <= f_blend(r_job.ax, r_job.bx, r_s);
                    r_py <= f_blend(r_job.ay, r_job.by, r_s);
                    r_pz <= f_blend(r_job.az, r_job.bz, r_t);
                    r_state <= B_QB;
                end
                B_QB: begin
                    // One quaternion component blend a cycle
                    r_b[r_qi] <= (48'(w_qa) <<< 16) + 48'(signed'({1'b0, r_t})) * 48'(w_qd);
                    r_qi <= r_qi + 2'd1;
                    if (r_qi == 2'd3) r_state <= B_SQ;
                end
                B_SQ: begin
                    // Blend magnitudes stay within 2^31
                    r_n2 <= r_n2 + 66'((64'(w_mag[31:0]) * 64'(w_mag[31:0])) >> 2);
                    r_qi <= r_qi + 2'd1;
                    if (r_qi == 2'd3) begin
                        r_state  <= B_SQRT;
                        r_sq_res <= '0;
                        r_sq_bit <= 66'd1 << 64;
                    end
                end
                B_SQRT: begin
                    // Bit-pair integer square root
                    if ({1'b0, r_n2} >= w_sq_t) begin
                        r_n2     <= r_n2 - w_sq_t[65:0];
                        r_sq_res <= (r_sq_res >> 1) + r_sq_bit;
                    end else begin
                        r_sq_res <= r_sq_res >> 1;
                    end
                    r_sq_bit <= r_sq_bit >> 2;
                    if (r_sq_bit == 66'd1) begin
                        r_state <= B_QDIV;
                        r_qi    <= 2'd0;
                        r_bit   <= 6'd0;
                    end
                end
                B_QDIV: begin
                    if (r_bit == 6'd0) begin
                        // Load divide of |b|*8192 + h/2 by h
                        r_rem <= '0;
                        r_num <= 49'((64'(w_mag) << 13) + 64'(w_h >> 1));
                        r_quo <= '0;
                        r_div <= 48'(w_h);
                        r_bit <= 6'd49;
                    end else begin
                        if (!w_trial[49]) begin
                            r_rem <= w_trial[48:0];
                            r_quo <= {r_quo[47:0], 1'b1};
                        end else begin
                            r_rem <= {r_rem[47:0], r_num[48]};
                            r_quo <= {r_quo[47:0], 1'b0};
                        end
                        r_num <= r_num << 1;
                        r_bit <= r_bit - 6'd1;
                        if (r_bit == 6'd1) begin
                            r_qi <= r_qi + 2'd1;
                            if (r_qi == 2'd3) r_state <= B_OUT;
                        end
                    end
                end
                B_OUT: if (!r_pv || i_pose_ready) begin
                    r_pv <= 1'b1;
                    r_j  <= r_j + 6'd1;
                    if (r_j == r_job.count) begin
                        r_state <= B_IDLE;
                    end else begin
                        r_state <= B_TDIV;
                        r_num   <= (49'(r_j + 6'd1) << 42) + (49'(r_job.count >> 1) << 26);
                        r_rem   <= '0;
                        r_quo   <= '0;
                        r_div   <= 48'(r_job.count);
                        r_bit   <= 6'd23;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    // Latch each normalized component as its divide ends; load the pose beat
    always_ff @(posedge i_clk) begin
        logic [48:0] v_q;
        logic [15:0] v_r;
        v_q = !w_trial[49] ? {r_quo[47:0], 1'b1} : {r_quo[47:0], 1'b0};
        v_r = (v_q > 49'd16384) ? 16'd16384 : 16'(v_q);
        if (r_state == B_QDIV && r_bit == 6'd1) begin
            if (w_h == 33'd0) r_q[r_qi] <= (r_qi == 2'd3) ? wsi_pkg::QUAT_ONE : 16'sd0;
            else r_q[r_qi] <= r_b[r_qi][47] ? -signed'(v_r) : signed'(v_r);
        end
        if (w_load) begin
            r_pose.out_x  <= r_px;
            r_pose.out_y  <= r_py;
            r_pose.out_z  <= r_pz;
            r_pose.out_qx <= r_q[0];
            r_pose.out_qy <= r_q[1];
            r_pose.out_qz <= r_q[2];
            r_pose.out_qw <= r_q[3];
            r_pose.segment_last <= (r_j == r_job.count);
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pv && !i_pose_ready) |=> $stable(r_pose))
        else $error("pose changed while stalled");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != B_IDLE) |-> (r_j <= r_job.count))
        else $error("pose index past count");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && r_j == r_job.count) |=> r_pose.segment_last)
        else $error("segment end out of step");

endmodule

// File: src/waypoint_smoothstep_interpolator.sv
// ----------------------------------------------------------------------------
// waypoint_smoothstep_interpolator: waypoint to smoothed pose stream
// channel   dir  payload
// way       in   path_start, way_x/y/z, way_qx/qy/qz/qw
// pose      out  out_x/y/z, out_qx/qy/qz/qw, segment_last
// cfg       in   step_resolution (32 bits)
// A segment passes intake and step counting in the front; each pose in the
// back then runs the 23-step t divide, the 33-step square root and four
// normalizing divides. Reset is synchronous.
// The front takes the next waypoint while the back still emits poses; the
// pose register holds under stall.
// ----------------------------------------------------------------------------
module waypoint_smoothstep_interpolator #(
    parameter int unsigned MAX_STEPS = 63
) (
    input  logic i_clk,
    input  logic i_rst_n,
    wsi_if.sink   way,
    wsi_if.sink   cfg,
    wsi_if.source pose
);
    logic [31:0]   r_res;
    logic          w_jv, w_jr, w_qv, w_qr;
    wsi_pkg::t_job w_job, w_qjob;

    assign cfg.ready = 1'b1;

    // Hold the step resolution register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_res <= wsi_pkg::RES_RESET;
        else if (cfg.valid) r_res <= cfg.data;
    end

    wsi_front #(.MAX_STEPS(MAX_STEPS)) u_front (
        .i_clk, .i_rst_n, .i_res(r_res),
        .i_way_valid(way.valid), .o_way_ready(way.ready), .i_way(way.data),
        .o_job_valid(w_jv), .i_job_ready(w_jr), .o_job(w_job)
    );

    wsi_queue u_queue (
        .i_clk, .i_rst_n,
        .i_valid(w_jv), .o_ready(w_jr), .i_data(w_job),
        .o_valid(w_qv), .i_ready(w_qr), .o_data(w_qjob)
    );

    wsi_back u_back (
        .i_clk, .i_rst_n,
        .i_job_valid(w_qv), .o_job_ready(w_qr), .i_job(w_qjob),
        .o_pose_valid(pose.valid), .i_pose_ready(pose.ready), .o_pose(pose.data)
    );

endmodule

// File: verif/waypoint_smoothstep_interpolator_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// waypoint_smoothstep_interpolator_test: self-checking bench for the
// waypoint interpolator.
// Feeds waypoint paths under several step resolutions, predicts every pose
// of each segment in fixed point, and compares each pose beat field by field
// while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module waypoint_smoothstep_interpolator_test;

    localparam int unsigned STEP_CAP   = 63;
    localparam int unsigned SETTLE_CYC = 400;

    logic i_clk;
    logic i_rst_n;

    wsi_if #(.T(wsi_pkg::t_way))  way_ch ();
    wsi_if #(.T(logic [31:0]))    cfg_ch ();
    wsi_if #(.T(wsi_pkg::t_pose)) pose_ch ();

    waypoint_smoothstep_interpolator #(.MAX_STEPS(STEP_CAP)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .way     (way_ch),
        .cfg     (cfg_ch),
        .pose    (pose_ch)
    );

    // Waypoints waiting for the driver, poses waiting for the monitor
    wsi_pkg::t_way  pending_ways[$];
    wsi_pkg::t_pose expected_poses[$];

    // Predictor state
    logic [31:0] res_reg;
    longint      last_x, last_y, last_z;
    longint      last_q[4];
    bit          have_last;

    // Generator side: last queued waypoint
    longint      gen_x, gen_y, gen_z;

    int unsigned errors;
    int unsigned way_beats;
    int unsigned pose_beats;
    int unsigned settings_seen;
    int unsigned way_gap;
    int unsigned pose_stall;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Ends a hung run
    initial begin
        #200ms;
        $display("Timeout at %0t", $time);
        $display("== FAIL ==");
        $finish;
    end

    function automatic longint unsigned abs64(longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned root = 0;
        longint unsigned bitv = 64'h4000_0000_0000_0000;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v    = v - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    // a + sign(b-a)*round(|b-a|*w/65536), half away from zero
    function automatic longint mix(longint a, longint b, longint unsigned w);
        longint          d;
        longint unsigned r;
        d = b - a;
        r = (abs64(d) * w + 32768) >> 16;
        return (d < 0) ? a - longint'(r) : a + longint'(r);
    endfunction

    // Largest n in 3..cap with (n*res)^2 <= dx^2 + dy^2, else 2
    function automatic int unsigned span_steps(longint dx, longint dy);
        logic [127:0] dist2;
        logic [127:0] stride;
        int unsigned  cnt;
        dist2 = 128'(abs64(dx)) * 128'(abs64(dx)) + 128'(abs64(dy)) * 128'(abs64(dy));
        cnt = 2;
        for (int unsigned n = 3; n <= STEP_CAP; n++) begin
            stride = 128'(n) * 128'(res_reg);
            if (stride * stride <= dist2) cnt = n;
            else break;
        end
        return cnt;
    endfunction

    // Expand one accepted waypoint into the poses of its segment
    function automatic void expand_waypoint(wsi_pkg::t_way w);
        longint          qn[4];
        longint          b[4];
        longint unsigned m[4];
        longint unsigned t, s, n2, h, r;
        int unsigned     cnt;
        longint          comp[4];
        wsi_pkg::t_pose  p;
        qn[0] = w.way_qx; qn[1] = w.way_qy; qn[2] = w.way_qz; qn[3] = w.way_qw;
        if (w.path_start || !have_last) begin
            last_x = w.way_x; last_y = w.way_y; last_z = w.way_z;
            last_q = qn;
            have_last = 1'b1;
            return;
        end
        cnt = span_steps(longint'(w.way_x) - last_x, longint'(w.way_y) - last_y);
        for (int unsigned j = 0; j <= cnt; j++) begin
            t = (longint'(j) * 65536 + cnt / 2) / cnt;
            s = (t * t * (3 * 65536 - 2 * t) + 64'h8000_0000) >> 32;
            p.out_x = 32'(mix(last_x, w.way_x, s));
            p.out_y = 32'(mix(last_y, w.way_y, s));
            p.out_z = 32'(mix(last_z, w.way_z, t));
            n2 = 0;
            for (int i = 0; i < 4; i++) begin
                b[i] = last_q[i] * 65536 + longint'(t) * (qn[i] - last_q[i]);
                m[i] = abs64(b[i]);
                n2 += (m[i] * m[i]) >> 2;
            end
            h = floor_sqrt(n2);
            for (int i = 0; i < 4; i++) begin
                if (h == 0) begin
                    comp[i] = (i == 3) ? 16384 : 0;
                end else begin
                    r = (m[i] * 8192 + h / 2) / h;
                    if (r > 16384) r = 16384;
                    comp[i] = (b[i] < 0) ? -longint'(r) : longint'(r);
                end
            end
            p.out_qx = 16'(comp[0]);
            p.out_qy = 16'(comp[1]);
            p.out_qz = 16'(comp[2]);
            p.out_qw = 16'(comp[3]);
            p.segment_last = (j == cnt);
            expected_poses.insert(expected_poses.size(), p);
        end
        last_x = w.way_x; last_y = w.way_y; last_z = w.way_z;
        last_q = qn;
    endfunction

    function automatic int unsigned draw_wait();
        return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 5);
    endfunction

    // Waypoint driver: hold each beat until taken, then idle a drawn gap
    always @(posedge i_clk) begin
        logic nv;
        if (!i_rst_n) begin
            way_ch.valid <= 1'b0;
            way_gap = 0;
        end else begin
            nv = way_ch.valid;
            if (way_ch.valid && way_ch.ready) begin
                expand_waypoint(way_ch.data);
                way_beats++;
                nv = 1'b0;
            end
            if (!nv) begin
                if (way_gap != 0) begin
                    way_gap--;
                end else if (pending_ways.size() != 0) begin
                    way_ch.data <= pending_ways.pop_front();
                    nv = 1'b1;
                    way_gap = draw_wait();
                end
            end
            way_ch.valid <= nv;
        end
    end

    task automatic check_field(string name, longint want, longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // Pose monitor: check each beat against the oldest expectation
    always @(posedge i_clk) begin
        wsi_pkg::t_pose want;
        wsi_pkg::t_pose got;
        if (!i_rst_n) begin
            pose_ch.ready <= 1'b0;
            pose_stall = 0;
        end else begin
            if (pose_ch.valid && pose_ch.ready) begin
                got = pose_ch.data;
                pose_beats++;
                pose_stall = draw_wait();
                if (expected_poses.size() == 0) begin
                    $display("%0t: unexpected pose, expected none, actual x=%0d y=%0d",
                             $time, got.out_x, got.out_y);
                    errors++;
                end else begin
                    want = expected_poses.pop_front();
                    check_field("out_x", want.out_x, got.out_x);
                    check_field("out_y", want.out_y, got.out_y);
                    check_field("out_z", want.out_z, got.out_z);
                    check_field("out_qx", want.out_qx, got.out_qx);
                    check_field("out_qy", want.out_qy, got.out_qy);
                    check_field("out_qz", want.out_qz, got.out_qz);
                    check_field("out_qw", want.out_qw, got.out_qw);
                    check_field("segment_last", want.segment_last, got.segment_last);
                end
            end
            if (pose_stall != 0) begin
                pose_stall--;
                pose_ch.ready <= 1'b0;
            end else begin
                pose_ch.ready <= 1'b1;
            end
        end
    end

    task automatic add_way(bit start, longint x, longint y, longint z,
                           longint qx, longint qy, longint qz, longint qw);
        wsi_pkg::t_way w;
        w.path_start = start;
        w.way_x = 32'(x); w.way_y = 32'(y); w.way_z = 32'(z);
        w.way_qx = 16'(qx); w.way_qy = 16'(qy); w.way_qz = 16'(qz); w.way_qw = 16'(qw);
        gen_x = w.way_x; gen_y = w.way_y; gen_z = w.way_z;
        pending_ways.insert(pending_ways.size(), w);
    endtask

    function automatic longint rand_quat();
        if ($urandom_range(0, 9) == 0) return longint'($signed(16'($urandom())));
        return longint'($urandom_range(0, 32768)) - 16384;
    endfunction

    // Offset of up to span, reflected to stay in the 32-bit range
    function automatic longint step_from(longint base, longint unsigned span);
        longint d;
        longint v;
        d = longint'($urandom_range(0, 1000)) * longint'(span) / 1000;
        if ($urandom_range(0, 1)) d = -d;
        v = base + d;
        if (v > 64'sh7FFF_FFFF || v < -64'sh8000_0000) v = base - d;
        return v;
    endfunction

    task automatic add_random_walk(int unsigned n, int unsigned max_strides);
        longint unsigned span;
        for (int unsigned i = 0; i < n; i++) begin
            span = longint'(res_reg) * $urandom_range(0, max_strides);
            if ($urandom_range(0, 29) == 0) span = longint'(res_reg) * 70;
            add_way($urandom_range(0, 9) == 0,
                    step_from(gen_x, span), step_from(gen_y, span),
                    step_from(gen_z, longint'(res_reg) * 8),
                    rand_quat(), rand_quat(), rand_quat(), rand_quat());
        end
    endtask

    task automatic add_random_full(int unsigned n);
        for (int unsigned i = 0; i < n; i++)
            add_way($urandom_range(0, 9) == 0,
                    longint'($signed($urandom())), longint'($signed($urandom())),
                    longint'($signed($urandom())),
                    rand_quat(), rand_quat(), rand_quat(), rand_quat());
    endtask

    // Sample between edges so that both clocked processes have settled
    task automatic wait_idle();
        while (pending_ways.size() != 0 || way_ch.valid || expected_poses.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // Write the resolution register while the block is idle
    task automatic set_resolution(logic [31:0] v);
        wait_idle();
        cfg_ch.data  <= v;
        cfg_ch.valid <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (cfg_ch.ready) break;
        end
        res_reg = v;
        settings_seen++;
        cfg_ch.valid <= 1'b0;
    endtask

    // Stimulus and end of run
    initial begin
        way_ch.valid  = 1'b0;
        way_ch.data   = '0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.data   = '0;
        pose_ch.ready = 1'b0;
        res_reg   = wsi_pkg::RES_RESET;
        have_last = 1'b0;
        last_x = 0; last_y = 0; last_z = 0;
        last_q = '{0, 0, 0, 0};
        gen_x = 0; gen_y = 0; gen_z = 0;
        errors = 0; way_beats = 0; pose_beats = 0; settings_seen = 1;
        i_rst_n = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: no previous waypoint after reset, extremes, zero norm,
        // out-of-range quaternions
        add_way(0, 100, 200, 300, 0, 0, 0, 16384);
        add_way(0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16384, 0, 0, 0);
        add_way(0, -32'sh8000_0000, -32'sh8000_0000, -32'sh8000_0000, -16384, 0, 0, 0);
        add_way(1, 0, 0, 0, 16384, 0, 0, 0);
        add_way(0, 1000, 0, -5, -16384, 0, 0, 0);
        add_way(0, 2000, 1, 7, 0, 11585, -11585, 0);
        add_way(0, 3000, 3, 9, 0, -11585, 11585, 0);
        add_way(0, 70000, -70000, 1, -32768, 32767, -32768, 32767);
        add_way(0, 70000, -70000, 1, 32767, -32768, 32767, -32768);
        add_way(0, 70000, -70000, 1, 0, 0, 0, 0);
        add_way(0, 70000, -70000, 1, 0, 0, 0, 0);
        add_way(1, -500000, 300000, 0, 1, 1, 1, 1);
        add_way(0, -500000 + 13107 * 5, 300000, 0, 8192, 8192, 8192, 8192);
        add_way(0, -500000 + 13107 * 5, 300000 + 13107 * 5, 0, 0, 0, 16384, 0);
        add_random_walk(50, 6);

        set_resolution(32'hFFFF_FFFF);
        add_random_full(90);

        set_resolution(32'd1);
        add_way(1, 0, 0, 0, 0, 0, 0, 16384);
        add_way(0, 5, -3, 2, 16384, 0, 0, 0);
        add_way(0, 6, -3, 2, 0, 16384, 0, 0);

        set_resolution(32'($urandom_range(16, 32'h0010_0000)));
        add_random_walk(55, 6);

        set_resolution(wsi_pkg::RES_RESET);
        add_random_walk(45, 6);

        wait_idle();
        $display("Run covered %0d waypoints and %0d poses over %0d resolution settings.",
                 way_beats, pose_beats, settings_seen);
        if (errors == 0 && expected_poses.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
